[design/spe_pkg.sv]
// shared types, constants and helpers for the spline point evaluator
package spe_pkg;

  localparam int MAX_KNOTS  = 16;
  localparam int COMPONENTS = 4;
  localparam int KIDX_W     = 4;
  localparam int CNT_W      = 5;
  localparam int COORD_W    = 32;
  localparam int KNOT_W     = COMPONENTS * COORD_W;
  localparam int ACC_W      = 40;
  localparam int T_W        = 19;
  localparam int U_W        = 17;
  localparam int FRAC_W     = 16;

  localparam logic [U_W-1:0] T_ONE = U_W'(1) << FRAC_W;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

  typedef enum logic [1:0] {
    MODE_BEZIER  = 2'd0,
    MODE_CATMULL = 2'd1,
    MODE_LINEAR  = 2'd2,
    MODE_FULL_CR = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECIDE, ST_CY0, ST_CY1, ST_CY2, ST_FRD, ST_FCAP, ST_LERP,
    ST_CA, ST_CB, ST_CC, ST_BRD0, ST_BLD0, ST_BRD, ST_BMUL, ST_BWR, ST_RES
  } state_e;

  typedef enum logic [1:0] {
    KIND_DIRECT, KIND_LINEAR, KIND_CR
  } kind_e;

  typedef enum logic [1:0] {
    SRC_EMPTY, SRC_P0, SRC_UNIT, SRC_CR
  } src_e;

  typedef logic [COMPONENTS-1:0][ACC_W-1:0]   acc_vec_t;
  typedef logic [COMPONENTS-1:0][COORD_W-1:0] knot_t;

  typedef struct packed {
    knot_t pt;
    logic  empty;
  } result_t;

  function automatic logic [ACC_W-1:0] sx32(logic [COORD_W-1:0] v);
    return {{(ACC_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic [COORD_W-1:0] sat32(logic signed [ACC_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v > SAT_HI) r = SAT_HI[COORD_W-1:0];
    else if (v < SAT_LO) r = SAT_LO[COORD_W-1:0];
    else r = v[COORD_W-1:0];
    return r;
  endfunction

endpackage

[design/spe_in_if.sv]
// input channel: knot writes and evaluate requests
interface spe_in_if;
  import spe_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [KIDX_W-1:0]         knot_index;
  logic signed [COORD_W-1:0] knot_x;
  logic signed [COORD_W-1:0] knot_y;
  logic signed [COORD_W-1:0] knot_z;
  logic signed [COORD_W-1:0] knot_w;
  logic signed [T_W-1:0]     param_t;
  modport source (output valid, action, knot_index, knot_x, knot_y, knot_z, knot_w,
                  param_t, input ready);
  modport sink (input valid, action, knot_index, knot_x, knot_y, knot_z, knot_w,
                param_t, output ready);
endinterface

[design/spe_out_if.sv]
// output channel: evaluated points
interface spe_out_if;
  import spe_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic signed [COORD_W-1:0] point_w;
  logic                      is_empty;
  modport source (output valid, point_x, point_y, point_z, point_w, is_empty, input ready);
  modport sink (input valid, point_x, point_y, point_z, point_w, is_empty, output ready);
endinterface

[design/spline_point_evaluator_core.sv]
// spline point evaluator: knot store, sequencer and output register
// Usage: knots (four Q16.16 components) are written by index with action 0
// beats on the input channel; an action 1 beat evaluates the curve at
// param_t (signed Q2.16, clamped to [0,1]) in the mode and over knot_count knots
// set on the config port (index 0 mode, index 1 knot_count). Each evaluate
// beat gives one output beat; write beats give none.
// A write beat leaves the input ready. An evaluate beat keeps the input not
// ready while the sequencer works through a single 4-lane multiply-round
// unit and one knot memory read port. A Bezier evaluation runs a lerp loop
// with one memory read, one unit pass and one scratch write per lerp.
// The result sits in an output register; the next item is accepted while
// it waits, and a further finished result holds until the receiver takes
// the previous one. Reset clears mode, knot_count and the output valid;
// the knot memory holds no reset value and must be written before use.
module spline_point_evaluator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [spe_pkg::CNT_W-1:0]   cfg_wdata_i,
  spe_in_if.sink                      in_i,
  spe_out_if.source                   out_o
);
  import spe_pkg::*;

  state_e state_q, state_d;
  mode_e  mode_q;
  logic [CNT_W-1:0] count_q;
  logic out_valid_q, out_valid_d;
  result_t out_q, out_d;

  logic [U_W-1:0]    t_q, t_d, u_q, u_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [KIDX_W-1:0] origin_q, origin_d, dir_addr_q, dir_addr_d;
  logic [KIDX_W-1:0] lvl_q, lvl_d, i_q, i_d;
  kind_e kind_q, kind_d;
  src_e  src_q, src_d;
  logic [2:0] nf_q, nf_d;
  logic [1:0] j_q, j_d;
  logic cyc_q, cyc_d;
  knot_t k0_q, k0_d, prev_q, prev_d;
  knot_t p_q [4];
  knot_t p_d [4];

  logic in_acc, knot_we, buf_we, unit_en, out_free, last_fetch, res_load;
  logic [KIDX_W-1:0] raddr;
  logic [KNOT_W-1:0] kdata, bdata, bsrc;
  acc_vec_t ux, uadd, ur, c1, c2, c3, crv;
  logic [3:0]  fac;
  logic [19:0] pos;
  logic [CNT_W-1:0] base, n_lim;
  logic t_one;

  // ---------- memories and shared unit ----------
  spe_ram u_knot_ram (
    .clk_i  (clk_i),
    .we_i   (knot_we),
    .waddr_i(in_i.knot_index),
    .wdata_i({in_i.knot_w, in_i.knot_z, in_i.knot_y, in_i.knot_x}),
    .raddr_i(raddr),
    .rdata_o(kdata)
  );

  logic [KNOT_W-1:0] buf_wdata;
  always_comb begin
    for (int c = 0; c < COMPONENTS; c++) begin
      buf_wdata[c*COORD_W +: COORD_W] = ur[c][COORD_W-1:0];
    end
  end

  spe_ram u_buf_ram (
    .clk_i  (clk_i),
    .we_i   (buf_we),
    .waddr_i(i_q),
    .wdata_i(buf_wdata),
    .raddr_i(raddr),
    .rdata_o(bdata)
  );

  spe_mac u_mac (
    .clk_i(clk_i),
    .en_i (unit_en),
    .x_i  (ux),
    .add_i(uadd),
    .u_i  (u_q),
    .r_o  (ur)
  );

  // ---------- shared decode ----------
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign knot_we    = in_acc && (in_i.action == ACT_WRITE);
  assign out_free   = !out_valid_q || out_o.ready;
  assign last_fetch = ({1'b0, j_q} == (nf_q - 3'd1));
  assign t_one      = t_q[U_W-1];
  // first Bezier level reads the knots, later ones the scratch buffer
  assign bsrc       = ({1'b0, lvl_q} == (n_q - CNT_W'(1))) ? kdata : bdata;
  assign fac        = (mode_q == MODE_CATMULL) ? 4'(n_q - CNT_W'(3)) : 4'(n_q - CNT_W'(1));
  assign pos        = t_q[FRAC_W-1:0] * fac;
  assign base       = CNT_W'(origin_q) + CNT_W'(j_q);
  assign n_lim      = count_q > CNT_W'(MAX_KNOTS) ? CNT_W'(MAX_KNOTS) : count_q;
  assign res_load   = (state_q == ST_RES) && out_free;

  always_comb begin
    for (int c = 0; c < COMPONENTS; c++) begin
      c1[c] = sx32(p_q[2][c]) - sx32(p_q[0][c]);
      c2[c] = (sx32(p_q[0][c]) <<< 1) - sx32(p_q[1][c]) * ACC_W'(5)
            + (sx32(p_q[2][c]) <<< 2) - sx32(p_q[3][c]);
      c3[c] = sx32(p_q[1][c]) * ACC_W'(3) - sx32(p_q[2][c]) * ACC_W'(3)
            + sx32(p_q[3][c]) - sx32(p_q[0][c]);
      crv[c] = ($signed(ur[c]) + $signed(sx32(p_q[1][c]) <<< 1) + ACC_W'(1)) >>> 1;
    end
  end

  // ---------- next state ----------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.action == ACT_EVAL) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (n_q == '0) state_d = ST_RES;
        else if (n_q == CNT_W'(1)) state_d = ST_FRD;
        else if (mode_q == MODE_BEZIER) state_d = ST_BRD0;
        else if (mode_q == MODE_CATMULL && n_q < CNT_W'(4)) state_d = ST_RES;
        else if (t_one) state_d = ST_FRD;
        else if (mode_q == MODE_FULL_CR) state_d = ST_CY0;
        else state_d = ST_FRD;
      end
      ST_CY0:  state_d = ST_CY1;
      ST_CY1:  state_d = ST_CY2;
      ST_CY2:  state_d = ST_FRD;
      ST_FRD:  state_d = ST_FCAP;
      ST_FCAP: begin
        if (!last_fetch) state_d = ST_FRD;
        else if (kind_q == KIND_DIRECT) state_d = ST_RES;
        else if (kind_q == KIND_LINEAR) state_d = ST_LERP;
        else state_d = ST_CA;
      end
      ST_LERP: state_d = ST_RES;
      ST_CA:   state_d = ST_CB;
      ST_CB:   state_d = ST_CC;
      ST_CC:   state_d = ST_RES;
      ST_BRD0: state_d = ST_BLD0;
      ST_BLD0: state_d = ST_BRD;
      ST_BRD:  state_d = ST_BMUL;
      ST_BMUL: state_d = ST_BWR;
      ST_BWR: begin
        if (i_q != lvl_q - KIDX_W'(1)) state_d = ST_BRD;
        else if (lvl_q == KIDX_W'(1)) state_d = ST_RES;
        else state_d = ST_BRD0;
      end
      ST_RES: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------- datapath control ----------
  always_comb begin
    t_d = t_q; n_d = n_q; u_d = u_q; origin_d = origin_q; dir_addr_d = dir_addr_q;
    lvl_d = lvl_q; i_d = i_q; kind_d = kind_q; src_d = src_q; nf_d = nf_q;
    j_d = j_q; cyc_d = cyc_q; k0_d = k0_q; prev_d = prev_q; p_d = p_q;
    raddr = '0; buf_we = 1'b0; unit_en = 1'b0; ux = '0; uadd = '0;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.action == ACT_EVAL) begin
          if (in_i.param_t < 0) t_d = '0;
          else if (in_i.param_t > $signed({2'b00, T_ONE})) t_d = T_ONE;
          else t_d = in_i.param_t[U_W-1:0];
          n_d = n_lim;
        end
      end
      ST_DECIDE: begin
        j_d = '0;
        nf_d = 3'd1;
        kind_d = KIND_DIRECT;
        src_d = SRC_P0;
        u_d = {1'b0, pos[FRAC_W-1:0]};
        origin_d = pos[19:16];
        lvl_d = 4'(n_q - CNT_W'(1));
        i_d = '0;
        cyc_d = 1'b0;
        if (mode_q == MODE_LINEAR || mode_q == MODE_FULL_CR) begin
          dir_addr_d = 4'(n_q - CNT_W'(1));
        end else begin
          dir_addr_d = 4'(n_q - CNT_W'(2));
        end
        if (n_q == '0) begin
          src_d = SRC_EMPTY;
        end else if (n_q == CNT_W'(1)) begin
          dir_addr_d = '0;
        end else if (mode_q == MODE_BEZIER) begin
          u_d = t_q;
          src_d = SRC_UNIT;
        end else if (mode_q == MODE_CATMULL && n_q < CNT_W'(4)) begin
          src_d = SRC_EMPTY;
        end else if (!t_one) begin
          if (mode_q == MODE_LINEAR) begin
            kind_d = KIND_LINEAR;
            nf_d = 3'd2;
            src_d = SRC_UNIT;
          end else begin
            kind_d = KIND_CR;
            nf_d = 3'd4;
            src_d = SRC_CR;
          end
        end
      end
      ST_CY0: raddr = '0;
      ST_CY1: begin
        raddr = 4'(n_q - CNT_W'(1));
        k0_d = kdata;
      end
      ST_CY2: cyc_d = (kdata == k0_q);
      ST_FRD: begin
        if (kind_q == KIND_DIRECT) begin
          raddr = dir_addr_q;
        end else if (mode_q != MODE_FULL_CR) begin
          raddr = base[KIDX_W-1:0];
        end else if (base == '0) begin
          raddr = cyc_q ? 4'(n_q - CNT_W'(2)) : '0;
        end else if (base == n_q + CNT_W'(1)) begin
          raddr = cyc_q ? KIDX_W'(1) : 4'(n_q - CNT_W'(1));
        end else begin
          raddr = 4'(base - CNT_W'(1));
        end
      end
      ST_FCAP: begin
        p_d[j_q] = kdata;
        j_d = j_q + 2'd1;
      end
      ST_LERP: begin
        unit_en = 1'b1;
        for (int c = 0; c < COMPONENTS; c++) begin
          ux[c] = sx32(p_q[1][c]) - sx32(p_q[0][c]);
          uadd[c] = sx32(p_q[0][c]);
        end
      end
      ST_CA: begin
        unit_en = 1'b1;
        ux = c3;
      end
      ST_CB: begin
        unit_en = 1'b1;
        for (int c = 0; c < COMPONENTS; c++) ux[c] = ur[c] + c2[c];
      end
      ST_CC: begin
        unit_en = 1'b1;
        for (int c = 0; c < COMPONENTS; c++) ux[c] = ur[c] + c1[c];
      end
      ST_BRD0: raddr = '0;
      ST_BLD0: prev_d = bsrc;
      ST_BRD:  raddr = i_q + KIDX_W'(1);
      ST_BMUL: begin
        unit_en = 1'b1;
        prev_d = bsrc;
        for (int c = 0; c < COMPONENTS; c++) begin
          ux[c] = sx32(bsrc[c*COORD_W +: COORD_W]) - sx32(prev_q[c]);
          uadd[c] = sx32(prev_q[c]);
        end
      end
      ST_BWR: begin
        buf_we = 1'b1;
        if (i_q != lvl_q - KIDX_W'(1)) begin
          i_d = i_q + KIDX_W'(1);
        end else begin
          i_d = '0;
          lvl_d = lvl_q - KIDX_W'(1);
        end
      end
      ST_RES: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.empty = (src_q == SRC_EMPTY);
          for (int c = 0; c < COMPONENTS; c++) begin
            case (src_q)
              SRC_EMPTY: out_d.pt[c] = '0;
              SRC_P0:    out_d.pt[c] = p_q[0][c];
              SRC_UNIT:  out_d.pt[c] = sat32(ur[c]);
              default:   out_d.pt[c] = sat32(crv[c]);
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  // ---------- registers ----------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_BEZIER;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MODE) mode_q <= mode_e'(cfg_wdata_i[1:0]);
        else count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d; n_q <= n_d; u_q <= u_d; origin_q <= origin_d; dir_addr_q <= dir_addr_d;
    lvl_q <= lvl_d; i_q <= i_d; kind_q <= kind_d; src_q <= src_d; nf_q <= nf_d;
    j_q <= j_d; cyc_q <= cyc_d; k0_q <= k0_d; prev_q <= prev_d; p_q <= p_d;
    if (res_load) out_q <= out_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.point_x  = out_q.pt[0];
  assign out_o.point_y  = out_q.pt[1];
  assign out_o.point_z  = out_q.pt[2];
  assign out_o.point_w  = out_q.pt[3];
  assign out_o.is_empty = out_q.empty;

endmodule

[design/spe_ram.sv]
// knot-wide memory, one write port and one registered read port
module spe_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [spe_pkg::KIDX_W-1:0]   waddr_i,
  input  logic [spe_pkg::KNOT_W-1:0]   wdata_i,
  input  logic [spe_pkg::KIDX_W-1:0]   raddr_i,
  output logic [spe_pkg::KNOT_W-1:0]   rdata_o
);
  import spe_pkg::*;

  logic [KNOT_W-1:0] mem [MAX_KNOTS];
  logic [KNOT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/spe_mac.sv]
// shared unit, one lane per component: r = add + round(x * u / 65536)
module spe_mac (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  spe_pkg::acc_vec_t        x_i,
  input  spe_pkg::acc_vec_t        add_i,
  input  logic [spe_pkg::U_W-1:0]  u_i,
  output spe_pkg::acc_vec_t        r_o
);
  import spe_pkg::*;

  localparam int PROD_W = ACC_W + U_W + 1;

  logic signed [PROD_W-1:0] prod [COMPONENTS];
  logic signed [PROD_W-1:0] rnd  [COMPONENTS];
  acc_vec_t                 r_d;
  acc_vec_t                 r_q;

  always_comb begin
    for (int c = 0; c < COMPONENTS; c++) begin
      prod[c] = $signed(x_i[c]) * $signed({1'b0, u_i});
      rnd[c]  = (prod[c] + PROD_W'(32768)) >>> FRAC_W;
      r_d[c]  = add_i[c] + rnd[c][ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

[bench/testbench.sv]
// self-checking bench for the spline point evaluator core
`timescale 1ns / 100ps

module testbench;
  import spe_pkg::*;

  typedef struct {
    logic               action;
    logic [KIDX_W-1:0]  idx;
    logic [COORD_W-1:0] x, y, z, w;
    logic [T_W-1:0]     t;
  } knot_op_t;

  typedef struct packed {
    logic [COORD_W-1:0] x, y, z, w;
    logic               empty;
  } point_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_index_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  spe_in_if  in_ch ();
  spe_out_if out_ch ();

  spline_point_evaluator_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  knot_op_t pending_ops[$];
  point_t   expected_points[$];
  knot_op_t driven_op;
  longint   knot_mirror[MAX_KNOTS][COMPONENTS];
  logic [COORD_W-1:0] gen_knots[MAX_KNOTS][COMPONENTS];
  mode_e    cur_mode;
  int       cur_count;
  int       mismatches = 0;
  int       cycle_cnt = 0;
  int       hold_left = 0;
  bit       hold_done = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("spline_point_evaluator_core test failed");
    $finish;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // a calm window with no idling on either side
  function automatic bit roll_idle();
    if (cycle_cnt >= 6000 && cycle_cnt < 16000) return 1'b0;
    return $urandom_range(99) < 19;
  endfunction

  function automatic longint rnd16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint lerp_fx(longint a, longint b, longint u);
    return a + rnd16((b - a) * u);
  endfunction

  function automatic logic [COORD_W-1:0] clip32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[COORD_W-1:0];
  endfunction

  function automatic int cr_slot(int i, int n, bit ext, bit cyc);
    if (!ext) return i;
    if (i == 0) return cyc ? n - 2 : 0;
    if (i == n + 1) return cyc ? 1 : n - 1;
    return i - 1;
  endfunction

  function automatic void catmull_point(int n, bit ext, longint t, output longint pt[4]);
    bit cyc;
    int m, origin, k;
    longint pos, u, p0, p1, p2, p3, c1, c2, c3, a, b, d;
    cyc = ext;
    m = ext ? n + 2 : n;
    if (ext)
      for (int c = 0; c < COMPONENTS; c++)
        if (knot_mirror[0][c] != knot_mirror[n-1][c]) cyc = 0;
    if (t >= 65536) begin
      k = cr_slot(m - 2, n, ext, cyc);
      for (int c = 0; c < COMPONENTS; c++) pt[c] = knot_mirror[k][c];
      return;
    end
    pos = t * (m - 3);
    origin = int'(pos >>> 16);
    u = pos & 64'hffff;
    if (origin > m - 4) origin = m - 4;
    for (int c = 0; c < COMPONENTS; c++) begin
      p0 = knot_mirror[cr_slot(origin, n, ext, cyc)][c];
      p1 = knot_mirror[cr_slot(origin + 1, n, ext, cyc)][c];
      p2 = knot_mirror[cr_slot(origin + 2, n, ext, cyc)][c];
      p3 = knot_mirror[cr_slot(origin + 3, n, ext, cyc)][c];
      c1 = p2 - p0;
      c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c3 = -p0 + 3 * p1 - 3 * p2 + p3;
      a = rnd16(c3 * u);
      b = rnd16((a + c2) * u);
      d = rnd16((b + c1) * u);
      pt[c] = (d + 2 * p1 + 1) >>> 1;
    end
  endfunction

  function automatic point_t eval_curve(logic [T_W-1:0] t_raw);
    longint pt[4];
    longint scratch[MAX_KNOTS][COMPONENTS];
    longint t, pos, u;
    int n, origin;
    bit empty;
    point_t r;
    pt = '{0, 0, 0, 0};
    empty = 0;
    n = cur_count > MAX_KNOTS ? MAX_KNOTS : cur_count;
    t = longint'($signed(t_raw));
    if (t < 0) t = 0;
    if (t > 65536) t = 65536;
    if (n == 0) empty = 1;
    else if (n == 1) begin
      for (int c = 0; c < COMPONENTS; c++) pt[c] = knot_mirror[0][c];
    end else if (cur_mode == MODE_BEZIER) begin
      scratch = knot_mirror;
      for (int lvl = n - 1; lvl > 0; lvl--)
        for (int i = 0; i < lvl; i++)
          for (int c = 0; c < COMPONENTS; c++)
            scratch[i][c] = lerp_fx(scratch[i][c], scratch[i+1][c], t);
      for (int c = 0; c < COMPONENTS; c++) pt[c] = scratch[0][c];
    end else if (cur_mode == MODE_LINEAR) begin
      if (t >= 65536) begin
        for (int c = 0; c < COMPONENTS; c++) pt[c] = knot_mirror[n-1][c];
      end else begin
        pos = t * (n - 1);
        origin = int'(pos >>> 16);
        u = pos & 64'hffff;
        if (origin > n - 2) origin = n - 2;
        for (int c = 0; c < COMPONENTS; c++)
          pt[c] = lerp_fx(knot_mirror[origin][c], knot_mirror[origin+1][c], u);
      end
    end else if (cur_mode == MODE_CATMULL) begin
      if (n < 4) empty = 1;
      else catmull_point(n, 0, t, pt);
    end else begin
      catmull_point(n, 1, t, pt);
    end
    if (empty) r = '{x: '0, y: '0, z: '0, w: '0, empty: 1'b1};
    else r = '{x: clip32(pt[0]), y: clip32(pt[1]), z: clip32(pt[2]), w: clip32(pt[3]),
               empty: 1'b0};
    return r;
  endfunction

  // sender side: hold the beat until taken, then update the mirror
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (driven_op.action == ACT_WRITE) begin
          knot_mirror[driven_op.idx][0] = longint'($signed(driven_op.x));
          knot_mirror[driven_op.idx][1] = longint'($signed(driven_op.y));
          knot_mirror[driven_op.idx][2] = longint'($signed(driven_op.z));
          knot_mirror[driven_op.idx][3] = longint'($signed(driven_op.w));
        end else begin
          expected_points.push_back(eval_curve(driven_op.t));
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ops.size() > 0 && !roll_idle()) begin
          driven_op = pending_ops.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.action     <= driven_op.action;
          in_ch.knot_index <= driven_op.idx;
          in_ch.knot_x     <= driven_op.x;
          in_ch.knot_y     <= driven_op.y;
          in_ch.knot_z     <= driven_op.z;
          in_ch.knot_w     <= driven_op.w;
          in_ch.param_t    <= driven_op.t;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [COORD_W-1:0] exp_v, logic [COORD_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // receiver side with one long hold-off to back the block up
  always @(posedge clk_i) begin
    point_t exp_p;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual %h", $time, out_ch.point_x);
          mismatches++;
        end else begin
          exp_p = expected_points.pop_front();
          check_field("point_x", exp_p.x, out_ch.point_x);
          check_field("point_y", exp_p.y, out_ch.point_y);
          check_field("point_z", exp_p.z, out_ch.point_z);
          check_field("point_w", exp_p.w, out_ch.point_w);
          check_field("is_empty", 32'(exp_p.empty), 32'(out_ch.is_empty));
        end
      end
      if (!hold_done && cycle_cnt > 3000 && expected_points.size() > 0) begin
        hold_done <= 1'b1;
        hold_left <= 900;
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !roll_idle();
      end
    end
  end

  task automatic write_reg(logic idx, logic [CNT_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MODE) cur_mode = mode_e'(val[1:0]);
    else cur_count = val;
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_ch.valid || expected_points.size() > 0)
      @(posedge clk_i);
    // writes give no beat, so let any evaluation in flight finish
    repeat (400) @(posedge clk_i);
  endtask

  task automatic set_curve(mode_e m, int cnt);
    wait_drained();
    write_reg(CFG_MODE, CNT_W'(m));
    write_reg(CFG_COUNT, CNT_W'(cnt));
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return '0;
      3: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [T_W-1:0] rand_param();
    case ($urandom_range(9))
      0: return '0;
      1: return T_W'(65536);
      2: return T_W'(-$signed($urandom_range(70000)));
      3: return T_W'(65536 + $urandom_range(65536));
      4: return T_W'($urandom);
      default: return T_W'($urandom_range(65536));
    endcase
  endfunction

  task automatic push_knot(int idx, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z, logic [COORD_W-1:0] w);
    knot_op_t op;
    op = '{action: ACT_WRITE, idx: KIDX_W'(idx), x: x, y: y, z: z, w: w, t: T_W'($urandom)};
    gen_knots[idx] = '{x, y, z, w};
    pending_ops.push_back(op);
  endtask

  task automatic push_eval(logic [T_W-1:0] t);
    knot_op_t op;
    op = '{action: ACT_EVAL, idx: KIDX_W'($urandom), x: $urandom, y: $urandom, z: $urandom,
           w: $urandom, t: t};
    pending_ops.push_back(op);
  endtask

  initial begin
    int issued, cnt, len;
    mode_e m;
    logic [T_W-1:0] edge_t[5];
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_MODE;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_WRITE;
    in_ch.knot_index = '0;
    in_ch.knot_x = '0;
    in_ch.knot_y = '0;
    in_ch.knot_z = '0;
    in_ch.knot_w = '0;
    in_ch.param_t = '0;
    out_ch.ready = 1'b0;
    cur_mode = MODE_BEZIER;
    cur_count = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill every slot first so no unwritten knot is ever read
    push_knot(0, 32'h7fffffff, 32'h80000000, 0, 32'h00010000);
    push_knot(1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 0);
    push_knot(2, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
    for (int i = 3; i < MAX_KNOTS; i++) push_knot(i, rand_coord(), rand_coord(), rand_coord(),
                                                  rand_coord());
    edge_t = '{T_W'(-5), '0, T_W'(32768), T_W'(65536), T_W'(131072)};
    set_curve(MODE_BEZIER, 0);
    push_eval(T_W'(32768));
    set_curve(MODE_LINEAR, 1);
    push_eval(T_W'(40000));
    set_curve(MODE_CATMULL, 3);
    push_eval(T_W'(1000));
    set_curve(MODE_CATMULL, 4);
    foreach (edge_t[i]) push_eval(edge_t[i]);
    set_curve(MODE_LINEAR, 2);
    push_eval('0);
    push_eval(T_W'(65536));
    set_curve(MODE_FULL_CR, 4);
    push_eval(T_W'(65536));
    push_knot(3, gen_knots[0][0], gen_knots[0][1], gen_knots[0][2], gen_knots[0][3]);
    push_eval(T_W'(20000));
    push_eval(T_W'(65536));
    set_curve(MODE_BEZIER, 16);
    push_eval(T_W'(30000));
    set_curve(MODE_FULL_CR, 20);
    push_eval(T_W'(50000));

    issued = 0;
    while (issued < 1850) begin
      m = mode_e'($urandom_range(3));
      cnt = ($urandom_range(7) == 0) ? $urandom_range(16) : $urandom_range(2, 6);
      set_curve(m, cnt);
      len = $urandom_range(50, 100);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(99) < 70) push_eval(rand_param());
        else if (cnt >= 2 && $urandom_range(3) == 0)
          push_knot(cnt - 1, gen_knots[0][0], gen_knots[0][1], gen_knots[0][2],
                    gen_knots[0][3]);
        else
          push_knot($urandom_range(MAX_KNOTS - 1), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord());
      end
      issued += len;
    end

    wait_drained();
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("spline_point_evaluator_core test passed");
    end else begin
      $display("spline_point_evaluator_core test failed");
    end
    $finish;
  end

endmodule
